FILE: hdl/ceq_pkg.sv
// Shared constants, types and codes of the coalescing error event queue.
package ceq_pkg;

  localparam int ERROR_COUNT = 256;
  localparam int RING_DEPTH  = 16;

  localparam int CMD_W      = 2;
  localparam int CODE_W     = 8;
  localparam int CNT_W      = 16;
  localparam int TIME_W     = 32;
  localparam int BOARD_W    = 6;
  localparam int INFO_W     = 32;
  localparam int DROP_W     = 16;
  localparam int INFO_CNT_W = 10;
  localparam int INFO_ID_W  = 16;
  localparam int ERR_IDX_W  = $clog2(ERROR_COUNT);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  localparam logic [CNT_W-1:0]  CNT_MAX  = 16'hFFFF;
  localparam logic [DROP_W-1:0] DROP_MAX = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_RAISE = 2'd0,
    CMD_SCAN  = 2'd1,
    CMD_SEND  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INC,
    CELL_SHIFT,
    CELL_LOAD
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [CODE_W-1:0] id;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic raise;
    logic step;
  } flag_ctl_t;

  typedef struct packed {
    logic              hit;
    logic              last;
    logic [CODE_W-1:0] code;
  } flag_sts_t;

endpackage

FILE: hdl/ceq_intf.sv
// Channel interfaces: event input, report output and configuration write.
interface ceq_evt_if import ceq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CODE_W-1:0] raise_code;
  logic [TIME_W-1:0] timestamp;

  modport source (output valid, command, raise_code, timestamp, input ready);
  modport sink   (input valid, command, raise_code, timestamp, output ready);
endinterface

interface ceq_rpt_if import ceq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] event_code;
  logic [CNT_W-1:0]  frequency;
  logic [TIME_W-1:0] first_stamp;
  logic [INFO_W-1:0] info_word;
  logic [DROP_W-1:0] overflow_count;

  modport source (output valid, event_code, frequency, first_stamp, info_word,
                  overflow_count, input ready);
  modport sink   (input valid, event_code, frequency, first_stamp, info_word,
                  overflow_count, output ready);
endinterface

interface ceq_cfg_if import ceq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BOARD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/coalescing_error_event_queue_unit.sv
// Top level of the coalescing error event queue: control, ring cell chain, report register.
// A send's report is held in the output register from the next cycle until taken. During
// a scan tick the scan pointer visits one flag per cycle, pending or not, and the cell chain
// searches and updates the ring in that same cycle. Reset clears all pending flags, empties
// the ring, zeroes the drop count and sets the board number to zero.
module coalescing_error_event_queue_unit import ceq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ceq_evt_if.sink   evt_i,
  ceq_rpt_if.source rpt_o,
  ceq_cfg_if.sink   cfg_i
);

  state_e             state_q, state_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [DROP_W-1:0]  drop_q, drop_d;
  logic [BOARD_W-1:0] board_q;
  logic [TIME_W-1:0]  now_q;
  logic               out_valid_q, out_valid_d;
  entry_t             out_entry_q;
  logic [INFO_W-1:0]  out_info_q;
  logic [DROP_W-1:0]  out_drop_q;

  flag_ctl_t flag_ctl;
  flag_sts_t flag_sts;

  cmd_e   cmd;
  logic   evt_acc;
  logic   handle;
  logic   send;
  logic   full;
  logic   hit_any;
  entry_t new_entry;

  entry_t   entries [RING_DEPTH];
  logic     found   [RING_DEPTH+1];
  cell_op_e cell_op [RING_DEPTH];

  assign cmd     = cmd_e'(evt_i.command);
  assign evt_acc = evt_i.valid && evt_i.ready;
  assign full    = (fill_q == FILL_W'(RING_DEPTH));
  assign hit_any = found[RING_DEPTH];
  assign found[0] = 1'b0;

  assign new_entry.id    = flag_sts.code;
  assign new_entry.count = CNT_W'(1);
  assign new_entry.stamp = now_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (evt_acc && (cmd == CMD_SCAN)) state_d = ST_SCAN;
      ST_SCAN: if (flag_sts.last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    evt_i.ready    = (state_q == ST_IDLE) && (!out_valid_q || rpt_o.ready);
    flag_ctl.raise = evt_acc && (cmd == CMD_RAISE);
    flag_ctl.step  = (state_q == ST_SCAN);
    handle         = flag_ctl.step && flag_sts.hit;
    send           = evt_acc && (cmd == CMD_SEND) && (fill_q != '0);
  end

  ceq_flag_scan u_flags (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (flag_ctl),
    .raise_code_i (evt_i.raise_code),
    .sts_o        (flag_sts)
  );

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    always_comb begin
      cell_op[i] = CELL_HOLD;
      priority if (send) begin
        cell_op[i] = CELL_SHIFT;
      end else if (handle) begin
        priority if (hit_any) begin
          cell_op[i] = CELL_INC;
        end else if (full) begin
          cell_op[i] = (i == RING_DEPTH - 1) ? CELL_LOAD : CELL_SHIFT;
        end else if (fill_q == FILL_W'(i)) begin
          cell_op[i] = CELL_LOAD;
        end else begin
          cell_op[i] = CELL_HOLD;
        end
      end else begin
        cell_op[i] = CELL_HOLD;
      end
    end

    ceq_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .valid_i (fill_q > FILL_W'(i)),
      .code_i  (flag_sts.code),
      .new_i   (new_entry),
      .next_i  ((i < RING_DEPTH - 1) ? entries[(i + 1) % RING_DEPTH] : new_entry),
      .found_i (found[i]),
      .entry_o (entries[i]),
      .found_o (found[i+1])
    );
  end

  always_comb begin
    fill_d      = fill_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    if (rpt_o.ready) out_valid_d = 1'b0;
    if (send) begin
      fill_d      = fill_q - 1'b1;
      drop_d      = '0;
      out_valid_d = 1'b1;
    end else if (handle && !hit_any) begin
      if (full) begin
        if (drop_q != DROP_MAX) drop_d = drop_q + 1'b1;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      drop_q      <= '0;
      board_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) board_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_acc && (cmd == CMD_SCAN)) now_q <= evt_i.timestamp;
    if (send) begin
      out_entry_q <= entries[0];
      out_drop_q  <= drop_q;
      out_info_q  <= {entries[0].count[INFO_CNT_W-1:0], board_q,
                      INFO_ID_W'(entries[0].id)};
    end
  end

  assign cfg_i.ready          = 1'b1;
  assign rpt_o.valid          = out_valid_q;
  assign rpt_o.event_code     = out_entry_q.id;
  assign rpt_o.frequency      = out_entry_q.count;
  assign rpt_o.first_stamp    = out_entry_q.stamp;
  assign rpt_o.info_word      = out_info_q;
  assign rpt_o.overflow_count = out_drop_q;

endmodule

FILE: hdl/ceq_cell.sv
// One ring entry cell: match, saturating count, shift from neighbor, load.
module ceq_cell import ceq_pkg::*; (
  input  logic              clk_i,
  input  cell_op_e          op_i,
  input  logic              valid_i,
  input  logic [CODE_W-1:0] code_i,
  input  entry_t            new_i,
  input  entry_t            next_i,
  input  logic              found_i,
  output entry_t            entry_o,
  output logic              found_o
);

  entry_t entry_q, entry_d;
  logic   match;

  always_comb begin
    match   = valid_i && (entry_q.id == code_i);
    found_o = found_i || match;
    entry_d = entry_q;
    unique case (op_i)
      CELL_HOLD: entry_d = entry_q;
      CELL_INC: begin
        if (match && !found_i && (entry_q.count != CNT_MAX)) begin
          entry_d.count = entry_q.count + 1'b1;
        end
      end
      CELL_SHIFT: entry_d = next_i;
      CELL_LOAD:  entry_d = new_i;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: hdl/ceq_flag_scan.sv
// Pending-flag bitmap with the ascending scan pointer.
module ceq_flag_scan import ceq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  flag_ctl_t         ctl_i,
  input  logic [CODE_W-1:0] raise_code_i,
  output flag_sts_t         sts_o
);

  logic [ERROR_COUNT-1:0] flags_q, flags_d;
  logic [ERR_IDX_W-1:0]   idx_q, idx_d;
  logic                   last;

  always_comb begin
    last    = (idx_q == ERR_IDX_W'(ERROR_COUNT - 1));
    flags_d = flags_q;
    idx_d   = idx_q;
    if (ctl_i.step) begin
      flags_d[idx_q] = 1'b0;
      idx_d          = last ? '0 : idx_q + 1'b1;
    end
    if (ctl_i.raise && (32'(raise_code_i) < ERROR_COUNT)) begin
      flags_d[raise_code_i[ERR_IDX_W-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      idx_q   <= '0;
    end else begin
      flags_q <= flags_d;
      idx_q   <= idx_d;
    end
  end

  assign sts_o.hit  = flags_q[idx_q];
  assign sts_o.last = last;
  assign sts_o.code = CODE_W'(idx_q);

endmodule

FILE: sim/tb_coalescing_error_event_queue_unit.sv
// Testbench for the coalescing error event queue: directed table, random bursts, report checks.
module tb_coalescing_error_event_queue_unit;
  import ceq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 2 * (ERROR_COUNT + 1);
  localparam int unsigned STALL_CYCLES  = 600;
  localparam int unsigned PHASE_ITEMS   = 265;
  localparam int unsigned DIRECTED_N    = 15;
  localparam int unsigned GROUP_SPAN    = ERROR_COUNT / RING_DEPTH;

  typedef struct packed {
    logic [CODE_W-1:0] event_code;
    logic [CNT_W-1:0]  frequency;
    logic [TIME_W-1:0] first_stamp;
    logic [INFO_W-1:0] info_word;
    logic [DROP_W-1:0] overflow_count;
  } report_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [CODE_W-1:0] code;
    logic [7:0]        span;
    logic [TIME_W-1:0] stamp;
    logic              pinned;
    logic              has_report;
    report_t           report;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{CMD_SEND,  8'h00, 8'd1,  32'h0000_0000, 1'b1, 1'b0, '0},
    '{CMD_RAISE, 8'h00, 8'd1,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_RAISE, 8'hFF, 8'd1,  32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{CMD_NONE,  8'hFF, 8'd1,  32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{CMD_SCAN,  8'h00, 8'd1,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_SEND,  8'h00, 8'd1,  32'h0000_0000, 1'b1, 1'b1,
      '{8'h00, 16'd1, 32'h0000_0000, 32'h007F_0000, 16'd0}},
    '{CMD_RAISE, 8'hFF, 8'd1,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_SCAN,  8'hA5, 8'd1,  32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{CMD_SEND,  8'h00, 8'd1,  32'h0000_0000, 1'b1, 1'b1,
      '{8'hFF, 16'd2, 32'h0000_0000, 32'h00BF_00FF, 16'd0}},
    '{CMD_SEND,  8'h00, 8'd1,  32'h0000_0000, 1'b1, 1'b0, '0},
    '{CMD_RAISE, 8'h01, 8'd17, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_SCAN,  8'h00, 8'd1,  32'h1234_5678, 1'b0, 1'b0, '0},
    '{CMD_RAISE, 8'h11, 8'd1,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{CMD_SCAN,  8'h00, 8'd1,  32'h0000_0005, 1'b0, 1'b0, '0},
    '{CMD_SEND,  8'h00, 8'd1,  32'h0000_0000, 1'b0, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  ceq_evt_if evt ();
  ceq_rpt_if rpt ();
  ceq_cfg_if cfg ();

  coalescing_error_event_queue_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt),
    .rpt_o  (rpt),
    .cfg_i  (cfg)
  );

  bit                 pend_q [ERROR_COUNT] = '{default: 1'b0};
  entry_t             ring_q [RING_DEPTH]  = '{default: '0};
  int unsigned        oldest_q     = 0;
  int unsigned        append_q     = 0;
  bit                 ring_empty_q = 1'b1;
  logic [DROP_W-1:0]  drops_q      = '0;
  logic [BOARD_W-1:0] board_q      = '0;

  report_t     expected_reports [$];
  int unsigned items_sent   = 0;
  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned stall_cnt    = 0;
  logic        stall_req;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int unsigned ring_next(input int unsigned pos);
    return (pos + 1 >= RING_DEPTH) ? 0 : pos + 1;
  endfunction

  function automatic void merge_code(input logic [CODE_W-1:0] code,
                                     input logic [TIME_W-1:0] now_stamp);
    int unsigned fill;
    int unsigned pos;
    if (ring_empty_q) begin
      fill = 0;
    end else if (append_q == oldest_q) begin
      fill = RING_DEPTH;
    end else begin
      fill = (append_q + RING_DEPTH - oldest_q) % RING_DEPTH;
    end
    pos = oldest_q;
    for (int k = 0; k < fill; k++) begin
      if (ring_q[pos].id == code) begin
        if (ring_q[pos].count != CNT_MAX) ring_q[pos].count = ring_q[pos].count + 1'b1;
        return;
      end
      pos = ring_next(pos);
    end
    // overwrite the oldest entry when the ring is full
    if (!ring_empty_q && append_q == oldest_q) begin
      if (drops_q != DROP_MAX) drops_q = drops_q + 1'b1;
      oldest_q = ring_next(oldest_q);
    end
    ring_q[append_q] = '{id: code, count: CNT_W'(1), stamp: now_stamp};
    append_q = ring_next(append_q);
    ring_empty_q = 1'b0;
  endfunction

  function automatic bit predict_report(input cmd_e cmd, input logic [CODE_W-1:0] code,
                                        input logic [TIME_W-1:0] now_stamp,
                                        output report_t report);
    entry_t head;
    report = '0;
    case (cmd)
      CMD_RAISE: begin
        if (int'(code) < ERROR_COUNT) pend_q[code] = 1'b1;
        return 1'b0;
      end
      CMD_SCAN: begin
        for (int c = 0; c < ERROR_COUNT; c++) begin
          if (pend_q[c]) begin
            pend_q[c] = 1'b0;
            merge_code(CODE_W'(c), now_stamp);
          end
        end
        return 1'b0;
      end
      CMD_SEND: begin
        if (ring_empty_q) return 1'b0;
        head = ring_q[oldest_q];
        report.event_code     = head.id;
        report.frequency      = head.count;
        report.first_stamp    = head.stamp;
        report.info_word      = {head.count[INFO_CNT_W-1:0], board_q, INFO_ID_W'(head.id)};
        report.overflow_count = drops_q;
        drops_q  = '0;
        oldest_q = ring_next(oldest_q);
        if (oldest_q == append_q) ring_empty_q = 1'b1;
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic drive_event(input cmd_e cmd, input logic [CODE_W-1:0] code,
                             input logic [TIME_W-1:0] now_stamp,
                             input bit pinned = 1'b0, input bit pinned_has = 1'b0,
                             input report_t pinned_rpt = '0);
    report_t next_report;
    bit      has;
    while ($urandom_range(99) < src_idle_pct) begin
      evt.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt.valid      <= 1'b1;
    evt.command    <= cmd;
    evt.raise_code <= code;
    evt.timestamp  <= now_stamp;
    @(posedge clk_i);
    while (evt.ready !== 1'b1) @(posedge clk_i);
    has = predict_report(cmd, code, now_stamp, next_report);
    if (pinned) begin
      has = pinned_has;
      next_report = pinned_rpt;
    end
    if (has) expected_reports.push_back(next_report);
    items_sent++;
  endtask

  task automatic drain();
    evt.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_board(input logic [BOARD_W-1:0] value);
    drain();
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    @(posedge clk_i);
    while (cfg.ready !== 1'b1) @(posedge clk_i);
    cfg.valid <= 1'b0;
    board_q = value;
  endtask

  task automatic run_bursts(input int unsigned count);
    int unsigned       stop_at;
    int unsigned       len;
    logic [CODE_W-1:0] code;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(20, 1);
        repeat (len) begin
          // favor a small set of codes so entries coalesce across ticks
          code = ($urandom_range(3) != 0) ? CODE_W'($urandom_range(11) * 21)
                                          : CODE_W'($urandom);
          drive_event(CMD_RAISE, code, $urandom);
        end
        drive_event(CMD_SCAN, CODE_W'($urandom), $urandom);
        repeat ($urandom_range(len + 2)) drive_event(CMD_SEND, CODE_W'($urandom), $urandom);
      end else begin
        drive_event(cmd_e'($urandom_range(3)), CODE_W'($urandom), $urandom);
      end
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && rpt.valid === 1'b1 && rpt.ready === 1'b1) begin
      if (expected_reports.size() == 0) begin
        $error("report transaction with nothing expected: id 0x%0h", rpt.event_code);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        check_field("event_code", want.event_code, rpt.event_code);
        check_field("frequency", want.frequency, rpt.frequency);
        check_field("first_stamp", want.first_stamp, rpt.first_stamp);
        check_field("info_word", want.info_word, rpt.info_word);
        check_field("overflow_count", want.overflow_count, rpt.overflow_count);
      end
    end
    if (stall_req && stall_cnt < STALL_CYCLES) begin
      stall_cnt <= stall_cnt + 1;
      rpt.ready <= 1'b0;
    end else begin
      if (!stall_req) stall_cnt <= 0;
      rpt.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    rst_ni         = 1'b0;
    stall_req      = 1'b0;
    evt.valid      = 1'b0;
    evt.command    = CMD_NONE;
    evt.raise_code = '0;
    evt.timestamp  = '0;
    cfg.valid      = 1'b0;
    cfg.data       = '0;
    rpt.ready      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_board(6'h3F);
    for (int r = 0; r < DIRECTED_N; r++) begin
      for (int i = 0; i < DIRECTED_ROWS[r].span; i++) begin
        drive_event(DIRECTED_ROWS[r].cmd, CODE_W'(DIRECTED_ROWS[r].code + i),
                    DIRECTED_ROWS[r].stamp, DIRECTED_ROWS[r].pinned,
                    DIRECTED_ROWS[r].has_report, DIRECTED_ROWS[r].report);
      end
    end

    src_idle_pct = 18;
    snk_idle_pct = 79;
    write_board(6'h00);
    run_bursts(PHASE_ITEMS);

    src_idle_pct = 79;
    snk_idle_pct = 18;
    write_board(BOARD_W'($urandom_range(62, 1)));
    run_bursts(PHASE_ITEMS);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_board(BOARD_W'($urandom));
    // fill the ring, then hold off the receiver while sends pile up
    for (int g = 0; g < RING_DEPTH; g++) begin
      drive_event(CMD_RAISE,
                  CODE_W'(g * GROUP_SPAN + $urandom_range(GROUP_SPAN - 1)),
                  $urandom);
    end
    drive_event(CMD_SCAN, CODE_W'($urandom), $urandom);
    stall_req <= 1'b1;
    repeat (12) drive_event(CMD_SEND, CODE_W'($urandom), $urandom);
    stall_req <= 1'b0;
    run_bursts(PHASE_ITEMS);

    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
